// File: src/lattice_shortest_vector_enum_unit_macros.svh
// assertion macros shared by the enumeration unit rtl
// depends on nothing; files that check their own logic include it
`ifndef LATTICE_SHORTEST_VECTOR_ENUM_UNIT_MACROS_SVH
`define LATTICE_SHORTEST_VECTOR_ENUM_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define LSVE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge out of reset
`define LSVE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/lsve_pkg.sv
// shared types, codes and constants of the lattice enumeration unit
// no dependencies; compiled first
`timescale 1ns / 1ps

package lsve_pkg;

  // build defaults
  localparam int MaxDimDefault   = 16;
  localparam int FracBitsDefault = 16;

  // field widths
  localparam int FuncW    = 2;
  localparam int IndexW   = 6;
  localparam int ValueW   = 32;
  localparam int DimW     = 7;
  localparam int RadiusW  = 31;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // datapath widths
  localparam int CoefW  = 16;
  localparam int CentW  = 32;
  localparam int PnW    = 48;
  localparam int NodeW  = 23;
  localparam int StepW  = 18;
  localparam int NvW    = 20;
  localparam int MulW   = 33;
  localparam int ProdW  = 66;

  localparam logic [NodeW-1:0]   NodeLimit   = 23'd4194304;
  localparam logic [DimW-1:0]    DimReset    = 7'd16;
  localparam logic [RadiusW-1:0] RadiusReset = 31'd100;
  localparam logic [PnW-1:0]     PnMax       = '1;

  typedef enum logic [FuncW-1:0] {
    FUNC_BASIS = 2'd0,
    FUNC_MU    = 2'd1,
    FUNC_NORM  = 2'd2,
    FUNC_START = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIMENSION = 2'd0,
    CFG_RADIUS    = 2'd1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_SQ,
    ST_EV_LO,
    ST_EV_HI,
    ST_EV_SUM,
    ST_EV_DEC,
    ST_C_RD,
    ST_C_MUL,
    ST_C_ACC,
    ST_C_FIN,
    ST_C_RND,
    ST_ASC,
    ST_O_RD,
    ST_O_MUL,
    ST_O_ACC,
    ST_O_PUT
  } state_e;

  // store write port
  typedef struct packed {
    logic                     en;
    func_e                    func;
    logic [IndexW-1:0]        row;
    logic [IndexW-1:0]        col;
    logic signed [ValueW-1:0] data;
  } mem_wr_t;

  // store read address
  typedef struct packed {
    logic [IndexW-1:0] row;
    logic [IndexW-1:0] col;
  } mem_req_t;

  // registered store read data
  typedef struct packed {
    logic signed [ValueW-1:0] basis;
    logic signed [ValueW-1:0] mu;
    logic signed [ValueW-1:0] norm;
  } mem_rd_t;

endpackage

// File: src/lsve_if.sv
// valid/ready channels of the lattice enumeration unit: input, result, config
// depends on lsve_pkg
`timescale 1ns / 1ps

interface lsve_in_if;
  import lsve_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FuncW-1:0]         func;
  logic [IndexW-1:0]        row_index;
  logic [IndexW-1:0]        col_index;
  logic signed [ValueW-1:0] load_value;
  modport source (output valid, func, row_index, col_index, load_value, input ready);
  modport sink   (input valid, func, row_index, col_index, load_value, output ready);
endinterface

interface lsve_out_if;
  import lsve_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IndexW-1:0]        coord_index;
  logic signed [ValueW-1:0] coord_value;
  logic                     found;
  logic                     last_coord;
  modport source (output valid, coord_index, coord_value, found, last_coord, input ready);
  modport sink   (input valid, coord_index, coord_value, found, last_coord, output ready);
endinterface

interface lsve_cfg_if;
  import lsve_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/lsve_mul.sv
// shared signed multiplier with registered product
// depends on lsve_pkg for operand widths
`timescale 1ns / 1ps

module lsve_mul (
  input  logic                              clk_i,
  input  logic signed [lsve_pkg::MulW-1:0]  a_i,
  input  logic signed [lsve_pkg::MulW-1:0]  b_i,
  output logic signed [lsve_pkg::ProdW-1:0] p_o
);
  import lsve_pkg::*;

  logic signed [ProdW-1:0] p_q;

  // one product per cycle, registered
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: src/lsve_store.sv
// basis, mu and squared norm memories with registered reads
// depends on lsve_pkg
`timescale 1ns / 1ps

module lsve_store #(
  parameter int MAX_DIM = lsve_pkg::MaxDimDefault
) (
  input  logic               clk_i,
  input  lsve_pkg::mem_wr_t  wr_i,
  input  lsve_pkg::mem_req_t req_i,
  output lsve_pkg::mem_rd_t  rd_o
);
  import lsve_pkg::*;

  localparam int MemD = MAX_DIM * MAX_DIM;
  localparam int MaW  = $clog2(MemD);
  localparam int NaW  = $clog2(MAX_DIM);

  logic signed [ValueW-1:0] basis_mem [MemD];
  logic signed [ValueW-1:0] mu_mem    [MemD];
  logic signed [ValueW-1:0] norm_mem  [MAX_DIM];
  logic signed [ValueW-1:0] basis_q;
  logic signed [ValueW-1:0] mu_q;
  logic signed [ValueW-1:0] norm_q;

  logic           row_ok;
  logic           col_ok;
  logic [MaW-1:0] waddr;
  logic [MaW-1:0] raddr;

  // address decode, out of range writes are dropped
  assign row_ok = ({1'b0, wr_i.row} < (IndexW + 1)'(MAX_DIM));
  assign col_ok = ({1'b0, wr_i.col} < (IndexW + 1)'(MAX_DIM));
  assign waddr  = MaW'(int'(wr_i.row) * MAX_DIM + int'(wr_i.col));
  assign raddr  = MaW'(int'(req_i.row) * MAX_DIM + int'(req_i.col));

  // basis memory
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.func == FUNC_BASIS && row_ok && col_ok) begin
      basis_mem[waddr] <= wr_i.data;
    end
    basis_q <= basis_mem[raddr];
  end

  // mu memory
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.func == FUNC_MU && row_ok && col_ok) begin
      mu_mem[waddr] <= wr_i.data;
    end
    mu_q <= mu_mem[raddr];
  end

  // squared norm memory
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.func == FUNC_NORM && row_ok) begin
      norm_mem[wr_i.row[NaW-1:0]] <= wr_i.data;
    end
    norm_q <= norm_mem[req_i.row[NaW-1:0]];
  end

  assign rd_o.basis = basis_q;
  assign rd_o.mu    = mu_q;
  assign rd_o.norm  = norm_q;

endmodule

// File: src/lsve_core.sv
// enumeration sequencer: zig-zag tree walk, center sums and coordinate output
// depends on lsve_pkg, lsve_if and the assertion macros; drives the shared multiplier and the store through ports
`timescale 1ns / 1ps
`include "lattice_shortest_vector_enum_unit_macros.svh"

module lsve_core #(
  parameter int MAX_DIM   = lsve_pkg::MaxDimDefault,
  parameter int FRAC_BITS = lsve_pkg::FracBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lsve_in_if.sink                            in_i,
  lsve_out_if.source                         out_o,
  input  logic [lsve_pkg::DimW-1:0]          dim_i,
  input  logic [lsve_pkg::RadiusW-1:0]       radius_i,
  output lsve_pkg::mem_wr_t                  mem_wr_o,
  output lsve_pkg::mem_req_t                 mem_req_o,
  input  lsve_pkg::mem_rd_t                  mem_rd_i,
  output logic signed [lsve_pkg::MulW-1:0]   mul_a_o,
  output logic signed [lsve_pkg::MulW-1:0]   mul_b_o,
  input  logic signed [lsve_pkg::ProdW-1:0]  mul_p_i
);
  import lsve_pkg::*;

  localparam int IdxW = $clog2(MAX_DIM);
  localparam int LvW  = $clog2(MAX_DIM + 2);
  localparam int PnIw = $clog2(MAX_DIM + 1);
  localparam int DW   = 34 + FRAC_BITS;
  localparam int QW   = 64 - FRAC_BITS;
  localparam int TW   = 97 - FRAC_BITS;
  localparam int AccW = 49 + $clog2(MAX_DIM);
  localparam logic [33:0] HalfLsb = 34'(2 ** (FRAC_BITS - 1));

  state_e state_q, state_d;

  // control registers
  logic [LvW-1:0]   level_q, top_q, n_q, i_q, j_q;
  logic [NodeW-1:0] nodes_q;
  logic [PnW-1:0]   radius_q;
  logic             found_q;

  // search vectors
  logic signed [CoefW-1:0] x_q    [MAX_DIM];
  logic signed [CentW-1:0] c_q    [MAX_DIM];
  logic [StepW-1:0]        step_q [MAX_DIM];
  logic [PnW-1:0]          pn_q   [MAX_DIM + 1];
  logic signed [CoefW-1:0] best_q [MAX_DIM];

  // datapath registers
  logic [DW-1:0]             ad_q;
  logic                      big_q;
  logic signed [ValueW-1:0]  b_q;
  logic [QW-1:0]             q_q;
  logic [63:0]               lo_q;
  logic [PnW-1:0]            term_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [CoefW-1:0]   xi_q;

  // output register
  logic                     out_valid_q;
  logic [IndexW-1:0]        out_idx_q;
  logic signed [ValueW-1:0] out_val_q;
  logic                     out_found_q;
  logic                     out_last_q;

  // decode and shared signals
  logic                    start_acc;
  logic [LvW-1:0]          lvm1, l1, n_start;
  logic [IdxW-1:0]         k0, ridx;
  logic signed [CoefW-1:0] x_r;
  logic signed [CentW-1:0] c_r;
  logic [StepW-1:0]        st_r;
  logic [PnW-1:0]          pn_r;
  logic signed [DW-1:0]    xf, cf, dd;
  logic [DW-1:0]           ad;
  logic [TW-1:0]           tot, tsh;
  logic [PnW-1:0]          term;
  logic [PnW:0]            psum;
  logic [PnW-1:0]          pn_new;
  logic                    less;
  logic signed [AccW:0]    nsum;
  logic signed [CentW-1:0] csat;
  logic [32:0]             cmag;
  logic [33:0]             rsum, rmag;
  logic signed [CoefW-1:0] rnd;
  logic                    is_top, past_n, ovr, gt;
  logic signed [NvW-1:0]   xe, se, nv;
  logic signed [ValueW-1:0] osat;
  logic                    limit_hit, i_more, oput_ok;
  logic [55:0]             rsh;
  logic [PnW-1:0]          rad0;

  assign start_acc = in_i.valid && in_i.ready && (func_e'(in_i.func) == FUNC_START);
  assign in_i.ready = (state_q == ST_IDLE);

  // store writes straight from load beats
  assign mem_wr_o.en   = in_i.valid && in_i.ready && (func_e'(in_i.func) != FUNC_START);
  assign mem_wr_o.func = func_e'(in_i.func);
  assign mem_wr_o.row  = in_i.row_index;
  assign mem_wr_o.col  = in_i.col_index;
  assign mem_wr_o.data = in_i.load_value;

  // level arithmetic and vector read index
  assign lvm1 = level_q - LvW'(1);
  assign l1   = level_q + LvW'(1);
  assign k0   = lvm1[IdxW-1:0];

  always_comb begin
    case (state_q)
      ST_C_RD, ST_O_RD: ridx = i_q[IdxW-1:0];
      ST_ASC:           ridx = level_q[IdxW-1:0];
      default:          ridx = k0;
    endcase
  end

  assign x_r  = x_q[ridx];
  assign c_r  = c_q[ridx];
  assign st_r = step_q[ridx];
  assign pn_r = pn_q[level_q[PnIw-1:0]];

  // dimension clamp and starting radius
  always_comb begin
    if (dim_i < DimW'(2)) begin
      n_start = LvW'(2);
    end else if (dim_i > DimW'(MAX_DIM)) begin
      n_start = LvW'(MAX_DIM);
    end else begin
      n_start = LvW'(dim_i);
    end
  end
  assign rsh  = 56'(radius_i) << FRAC_BITS;
  assign rad0 = (rsh > 56'(PnMax)) ? PnMax : rsh[PnW-1:0];

  // distance to center, absolute value
  assign xf = DW'(x_r) <<< FRAC_BITS;
  assign cf = DW'(c_r);
  assign dd = xf - cf;
  assign ad = dd[DW-1] ? DW'(-dd) : DW'(dd);

  // norm term from the split product, saturated
  assign tot = TW'(lo_q) + (TW'(mul_p_i[63:0]) << 32);
  assign tsh = tot >> FRAC_BITS;
  always_comb begin
    if (b_q <= 0) begin
      term = '0;
    end else if (big_q || (|tot[TW-1:64]) || (tsh > TW'(PnMax))) begin
      term = PnMax;
    end else begin
      term = tsh[PnW-1:0];
    end
  end

  // partial norm and radius compare
  assign psum   = {1'b0, pn_r} + {1'b0, term_q};
  assign pn_new = psum[PnW] ? PnMax : psum[PnW-1:0];
  assign less   = (pn_new < radius_q);

  // center saturation
  assign nsum = -((AccW + 1)'(acc_q));
  always_comb begin
    if (nsum[AccW:31] == {(AccW - 30){nsum[31]}}) begin
      csat = nsum[31:0];
    end else if (nsum[AccW]) begin
      csat = 32'sh8000_0000;
    end else begin
      csat = 32'sh7fff_ffff;
    end
  end

  // round half away from zero, saturate to coefficient width
  assign cmag = c_r[31] ? (33'd0 - {c_r[31], c_r}) : {1'b0, c_r};
  assign rsum = {1'b0, cmag} + HalfLsb;
  assign rmag = rsum >> FRAC_BITS;
  always_comb begin
    if (c_r[31]) begin
      rnd = (rmag > 34'd32768) ? 16'sh8000 : CoefW'(16'd0 - rmag[15:0]);
    end else begin
      rnd = (rmag > 34'd32767) ? 16'sh7fff : $signed(rmag[15:0]);
    end
  end

  // zig-zag step on ascent
  assign past_n = (l1 > n_q);
  assign is_top = (l1 >= top_q);
  assign gt     = (xf > cf);
  assign xe     = NvW'(x_r);
  assign se     = $signed(NvW'(st_r));
  always_comb begin
    if (is_top) begin
      nv = xe + NvW'(1);
    end else if (gt) begin
      nv = xe - se;
    end else begin
      nv = xe + se;
    end
  end
  assign ovr = (nv[NvW-1:15] != {(NvW - 15){nv[15]}});

  // coordinate saturation
  always_comb begin
    if (acc_q[AccW-1:31] == {(AccW - 31){acc_q[31]}}) begin
      osat = acc_q[31:0];
    end else if (acc_q[AccW-1]) begin
      osat = 32'sh8000_0000;
    end else begin
      osat = 32'sh7fff_ffff;
    end
  end

  assign limit_hit = (nodes_q == NodeLimit);
  assign i_more    = (LvW'(i_q + LvW'(1)) < n_q);
  assign oput_ok   = !out_valid_q || out_o.ready;

  // shared multiplier operands
  always_comb begin
    case (state_q)
      ST_EV_SQ: begin
        mul_a_o = {1'b0, ad_q[31:0]};
        mul_b_o = {1'b0, ad_q[31:0]};
      end
      ST_EV_LO: begin
        mul_a_o = {1'b0, mul_p_i[FRAC_BITS+31:FRAC_BITS]};
        mul_b_o = {b_q[ValueW-1], b_q};
      end
      ST_EV_HI: begin
        mul_a_o = MulW'(q_q[QW-1:32]);
        mul_b_o = {b_q[ValueW-1], b_q};
      end
      ST_C_MUL: begin
        mul_a_o = MulW'(xi_q);
        mul_b_o = MulW'(mem_rd_i.mu);
      end
      ST_O_MUL: begin
        mul_a_o = MulW'(xi_q);
        mul_b_o = MulW'(mem_rd_i.basis);
      end
      default: begin
        mul_a_o = '0;
        mul_b_o = '0;
      end
    endcase
  end

  // store read address
  always_comb begin
    mem_req_o.row = IndexW'(k0);
    mem_req_o.col = '0;
    case (state_q)
      ST_C_RD: begin
        mem_req_o.row = IndexW'(i_q);
        mem_req_o.col = IndexW'(k0);
      end
      ST_O_RD: begin
        mem_req_o.row = IndexW'(i_q);
        mem_req_o.col = IndexW'(j_q);
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_acc) state_d = ST_EV_RD;
      ST_EV_RD:  state_d = limit_hit ? ST_O_RD : ST_EV_SQ;
      ST_EV_SQ:  state_d = ST_EV_LO;
      ST_EV_LO:  state_d = ST_EV_HI;
      ST_EV_HI:  state_d = ST_EV_SUM;
      ST_EV_SUM: state_d = ST_EV_DEC;
      ST_EV_DEC: state_d = (less && level_q != LvW'(1)) ? ST_C_RD : ST_ASC;
      ST_C_RD:   state_d = ST_C_MUL;
      ST_C_MUL:  state_d = ST_C_ACC;
      ST_C_ACC:  state_d = i_more ? ST_C_RD : ST_C_FIN;
      ST_C_FIN:  state_d = ST_C_RND;
      ST_C_RND:  state_d = ST_EV_RD;
      ST_ASC: begin
        if (past_n) begin
          state_d = ST_O_RD;
        end else if (!ovr) begin
          state_d = ST_EV_RD;
        end
      end
      ST_O_RD:   state_d = ST_O_MUL;
      ST_O_MUL:  state_d = ST_O_ACC;
      ST_O_ACC:  state_d = i_more ? ST_O_RD : ST_O_PUT;
      ST_O_PUT: begin
        if (oput_ok) begin
          state_d = (j_q == LvW'(n_q - LvW'(1))) ? ST_IDLE : ST_O_RD;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_acc) begin
          for (int k = 0; k < MAX_DIM; k++) begin
            x_q[k]    <= (k == 0) ? CoefW'(1) : '0;
            c_q[k]    <= '0;
            step_q[k] <= '0;
            best_q[k] <= '0;
          end
          for (int k = 0; k <= MAX_DIM; k++) begin
            pn_q[k] <= '0;
          end
          n_q      <= n_start;
          found_q  <= 1'b0;
          radius_q <= rad0;
          level_q  <= LvW'(1);
          top_q    <= LvW'(1);
          nodes_q  <= '0;
        end
      end
      ST_EV_RD: begin
        if (limit_hit) begin
          i_q   <= '0;
          j_q   <= '0;
          acc_q <= '0;
        end else begin
          ad_q    <= ad;
          big_q   <= |ad[DW-1:32];
          nodes_q <= nodes_q + NodeW'(1);
        end
      end
      ST_EV_SQ:  b_q    <= mem_rd_i.norm;
      ST_EV_LO:  q_q    <= mul_p_i[63:FRAC_BITS];
      ST_EV_HI:  lo_q   <= mul_p_i[63:0];
      ST_EV_SUM: term_q <= term;
      ST_EV_DEC: begin
        pn_q[k0] <= pn_new;
        if (less) begin
          if (level_q == LvW'(1)) begin
            radius_q <= pn_new;
            found_q  <= 1'b1;
            for (int k = 0; k < MAX_DIM; k++) begin
              best_q[k] <= x_q[k];
            end
          end else begin
            level_q <= lvm1;
            i_q     <= lvm1;
            acc_q   <= '0;
          end
        end
      end
      ST_C_RD:  xi_q <= x_r;
      ST_C_ACC: begin
        acc_q <= acc_q + AccW'(mul_p_i);
        i_q   <= i_q + LvW'(1);
      end
      ST_C_FIN: c_q[k0] <= csat;
      ST_C_RND: begin
        x_q[k0]    <= rnd;
        step_q[k0] <= StepW'(1);
      end
      ST_ASC: begin
        if (past_n) begin
          i_q   <= '0;
          j_q   <= '0;
          acc_q <= '0;
        end else begin
          level_q <= l1;
          if (is_top) begin
            top_q <= l1;
          end
          if (!ovr) begin
            x_q[ridx] <= nv[CoefW-1:0];
            if (!is_top) begin
              step_q[ridx] <= st_r + StepW'(1);
            end
          end
        end
      end
      ST_O_RD:  xi_q <= best_q[i_q[IdxW-1:0]];
      ST_O_ACC: begin
        acc_q <= acc_q + AccW'(mul_p_i);
        i_q   <= i_q + LvW'(1);
      end
      ST_O_PUT: begin
        if (oput_ok) begin
          out_idx_q   <= IndexW'(j_q);
          out_val_q   <= osat;
          out_found_q <= found_q;
          out_last_q  <= (j_q == LvW'(n_q - LvW'(1)));
          j_q         <= j_q + LvW'(1);
          i_q         <= '0;
          acc_q       <= '0;
        end
      end
      default: ;
    endcase
  end

  // result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_O_PUT && oput_ok) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.coord_index = out_idx_q;
  assign out_o.coord_value = out_val_q;
  assign out_o.found       = out_found_q;
  assign out_o.last_coord  = out_last_q;

  // checks on the walk and the output register
  `LSVE_ASSERT_IMPL(a_level_le_top, clk_i, rst_ni, state_q != ST_IDLE, level_q <= top_q, "level above top level")
  `LSVE_ASSERT_IMPL(a_nodes_bound, clk_i, rst_ni, state_q != ST_IDLE, nodes_q <= NodeLimit, "node count past limit")
  `LSVE_ASSERT_IMPL(a_eval_level, clk_i, rst_ni, state_q == ST_EV_DEC, level_q != '0 && level_q <= n_q, "eval level out of range")
  `LSVE_ASSERT_IMPL(a_out_load, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_O_PUT), "result beat without output step")

endmodule

// File: src/lattice_shortest_vector_enum_unit.sv
// Lattice shortest vector enumeration unit.
// Channels: in_i takes load beats (basis, mu, squared norm entries) and start beats;
// out_o returns one beat per coordinate of the shortest vector found, with found
// and last_coord flags; cfg_i writes dimension and initial squared radius.
// A load beat is written to the store and produces no result. A start beat
// runs the enumeration: each tree node steps through read, square, low and
// high product, sum and decide on the shared multiplier; each descent reads,
// multiplies and accumulates every center sum term, then finishes and rounds
// the center; each level climbed takes an ascent step. Run length depends on
// the data, capped by the node budget. The output sums every basis term of a
// coordinate. in_i is not ready while a run or its output is in progress.
// A result waits in the output register when out_o stalls; the next coordinate
// is computed meanwhile and held until the register frees.
// Reset returns the sequencer to idle and sets dimension 16, radius 100; the
// memories keep no reset value and must be loaded before a run.
// depends on lsve_pkg, lsve_if, lsve_mul, lsve_store, lsve_core
`timescale 1ns / 1ps

module lattice_shortest_vector_enum_unit #(
  parameter int MAX_DIM   = lsve_pkg::MaxDimDefault,
  parameter int FRAC_BITS = lsve_pkg::FracBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsve_in_if.sink    in_i,
  lsve_out_if.source out_o,
  lsve_cfg_if.sink   cfg_i
);
  import lsve_pkg::*;

  logic [DimW-1:0]    dim_q;
  logic [RadiusW-1:0] radius_q;

  mem_wr_t                 mem_wr;
  mem_req_t                mem_req;
  mem_rd_t                 mem_rd;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;

  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= DimReset;
      radius_q <= RadiusReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_DIMENSION: dim_q    <= cfg_i.data[DimW-1:0];
        CFG_RADIUS:    radius_q <= cfg_i.data[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  lsve_store #(
    .MAX_DIM (MAX_DIM)
  ) u_store (
    .clk_i (clk_i),
    .wr_i  (mem_wr),
    .req_i (mem_req),
    .rd_o  (mem_rd)
  );

  lsve_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  lsve_core #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .dim_i     (dim_q),
    .radius_i  (radius_q),
    .mem_wr_o  (mem_wr),
    .mem_req_o (mem_req),
    .mem_rd_i  (mem_rd),
    .mul_a_o   (mul_a),
    .mul_b_o   (mul_b),
    .mul_p_i   (mul_p)
  );

endmodule

// File: tb/tb_lattice_shortest_vector_enum_unit.sv
// self-checking testbench of the lattice shortest vector enumeration unit
// depends on lsve_pkg, lsve_if and the unit rtl; drives all three channels
`timescale 1ns / 1ps

module tb_lattice_shortest_vector_enum_unit;
  import lsve_pkg::*;

  localparam int Dim       = MaxDimDefault;
  localparam int Frac      = FracBitsDefault;
  localparam int CycleCap  = 5000000;
  localparam int HoldLen   = 2000;
  localparam int NumRandom = 210;
  localparam logic [63:0] SatMax = (64'd1 << 48) - 64'd1;

  // one coordinate beat of the found vector
  typedef struct {
    logic [IndexW-1:0]        idx;
    logic signed [ValueW-1:0] val;
    logic                     fnd;
    logic                     lst;
  } coord_t;

  // one row of the directed stimulus
  typedef struct {
    func_e                    fn;
    logic [IndexW-1:0]        row;
    logic [IndexW-1:0]        col;
    logic signed [ValueW-1:0] value;
    bit                       zero_vec;
  } stim_t;

  logic clk;
  logic rst_n;

  lsve_in_if  in_if ();
  lsve_out_if out_if ();
  lsve_cfg_if cfg_if ();

  lattice_shortest_vector_enum_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the unit state
  int          basis_m [Dim][Dim];
  int          mu_m    [Dim][Dim];
  int          norm_m  [Dim];
  int          coef    [Dim];
  int          cent    [Dim];
  int          stp     [Dim];
  int          best    [Dim];
  logic [63:0] pnorm   [Dim+1];
  logic [63:0] radius;
  int          lvl;
  int          top_lvl;
  bit          found_f;
  int          dim_reg;
  int          rad_reg;

  coord_t coord_q[$];
  int     n_errors;
  int     n_items;
  int     n_starts;
  int     n_coords;
  int     n_found;
  bit     zero_pending;
  bit     hold_req;
  bit     quiet;

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // term added to the partial norm at one level
  function automatic logic [63:0] level_cost(longint d, int b);
    logic [63:0] ad;
    logic [63:0] q;
    logic [63:0] t;
    if (b <= 0) return 64'd0;
    ad = (d < 0) ? 64'(-d) : 64'(d);
    if (ad >= (64'd1 << 32)) return SatMax;
    q = (ad * ad) >> Frac;
    if (q > ({64{1'b1}} / 64'(b))) return SatMax;
    t = (q * 64'(b)) >> Frac;
    return (t > SatMax) ? SatMax : t;
  endfunction

  // center of level k from the coefficients above it
  function automatic int level_center(int k, int n);
    longint acc;
    acc = 0;
    for (int i = k + 1; i < n; i++) acc += longint'(coef[i]) * longint'(mu_m[i][k]);
    acc = -acc;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return int'(acc);
  endfunction

  // nearest integer, half away from zero, clipped to 16 bits
  function automatic int round_to_int(int c);
    longint mag;
    longint r;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    r = (mag + (64'sd1 <<< (Frac - 1))) >>> Frac;
    if (c < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  // zig-zag enumeration under the shrinking radius
  task automatic enumerate(int n);
    int          nodes;
    int          k;
    longint      d;
    longint      nv;
    logic [63:0] pn;
    logic [63:0] r0;
    bit          is_top;
    bit          done;
    bit          stepped;
    nodes = 0;
    done = 0;
    for (int i = 0; i < Dim; i++) begin
      coef[i] = (i == 0) ? 1 : 0;
      cent[i] = 0;
      stp[i]  = 0;
      best[i] = 0;
    end
    for (int i = 0; i <= Dim; i++) pnorm[i] = 0;
    found_f = 0;
    r0 = 64'(rad_reg);
    radius = (r0 > (SatMax >> Frac)) ? SatMax : (r0 << Frac);
    lvl = 1;
    top_lvl = 1;
    while (!done && nodes < int'(NodeLimit)) begin
      k = lvl - 1;
      d = longint'(coef[k]) * (64'sd1 <<< Frac) - longint'(cent[k]);
      pn = pnorm[lvl] + level_cost(d, norm_m[k]);
      nodes++;
      if (pn > SatMax) pn = SatMax;
      pnorm[k] = pn;
      if (pn < radius && lvl != 1) begin
        // descend one level and start at the rounded center
        lvl--;
        k = lvl - 1;
        cent[k] = level_center(k, n);
        coef[k] = round_to_int(cent[k]);
        stp[k] = 1;
      end else begin
        if (pn < radius) begin
          radius = pn;
          for (int i = 0; i < n; i++) best[i] = coef[i];
          found_f = 1;
        end
        // climb until a level can take its next step
        stepped = 0;
        while (!stepped && !done) begin
          lvl++;
          if (lvl > n) begin
            done = 1;
          end else begin
            k = lvl - 1;
            is_top = (lvl >= top_lvl);
            if (is_top) begin
              top_lvl = lvl;
              nv = longint'(coef[k]) + 1;
            end else if (longint'(coef[k]) * (64'sd1 <<< Frac) > longint'(cent[k])) begin
              nv = longint'(coef[k]) - stp[k];
            end else begin
              nv = longint'(coef[k]) + stp[k];
            end
            if (nv >= -32768 && nv <= 32767) begin
              coef[k] = int'(nv);
              if (!is_top) stp[k] += 1;
              stepped = 1;
            end
          end
        end
      end
    end
  endtask

  // apply one accepted input beat to the shadow state
  task automatic predict_item(logic [FuncW-1:0] fn, int row, int col, int value, bit zero_vec);
    int     n;
    longint s;
    coord_t c;
    case (func_e'(fn))
      FUNC_BASIS: if (row < Dim && col < Dim) basis_m[row][col] = value;
      FUNC_MU:    if (row < Dim && col < Dim) mu_m[row][col] = value;
      FUNC_NORM:  if (row < Dim) norm_m[row] = value;
      default: begin
        n = (dim_reg < 2) ? 2 : ((dim_reg > Dim) ? Dim : dim_reg);
        enumerate(n);
        for (int j = 0; j < n; j++) begin
          s = 0;
          for (int i = 0; i < n; i++) s += longint'(best[i]) * longint'(basis_m[i][j]);
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          if (s < -64'sd2147483648) s = -64'sd2147483648;
          c.idx = IndexW'(j);
          c.val = zero_vec ? '0 : ValueW'(s);
          c.fnd = zero_vec ? 1'b0 : found_f;
          c.lst = (j == n - 1);
          coord_q.push_back(c);
        end
        if (found_f) n_found++;
        n_starts++;
      end
    endcase
  endtask

  // input beat monitor
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      predict_item(in_if.func, int'(in_if.row_index), int'(in_if.col_index),
                   int'(in_if.load_value), zero_pending);
      zero_pending = 0;
      n_items++;
    end
  end

  // result beat checker
  always @(posedge clk) begin
    coord_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_coords++;
      if (coord_q.size() == 0) begin
        $display("%0t: unexpected coordinate beat idx=%0d val=%0d", $realtime,
                 out_if.coord_index, out_if.coord_value);
        n_errors++;
      end else begin
        e = coord_q.pop_front();
        if (out_if.coord_index !== e.idx) begin
          $display("%0t: coord_index expected %0d actual %0d", $realtime, e.idx,
                   out_if.coord_index);
          n_errors++;
        end
        if (out_if.coord_value !== e.val) begin
          $display("%0t: coord_value[%0d] expected %0d actual %0d", $realtime, e.idx, e.val,
                   out_if.coord_value);
          n_errors++;
        end
        if (out_if.found !== e.fnd) begin
          $display("%0t: found expected %0b actual %0b", $realtime, e.fnd, out_if.found);
          n_errors++;
        end
        if (out_if.last_coord !== e.lst) begin
          $display("%0t: last_coord expected %0b actual %0b", $realtime, e.lst,
                   out_if.last_coord);
          n_errors++;
        end
      end
    end
  end

  // result side: random stalls and one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldLen) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // cycle watchdog
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleCap) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // send one input beat, with an occasional gap before it
  task automatic send_item(func_e fn, int row, int col, int value);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= fn;
    in_if.row_index  <= IndexW'(row);
    in_if.col_index  <= IndexW'(col);
    in_if.load_value <= ValueW'(value);
    do @(posedge clk); while (!in_if.ready);
  endtask

  // write one register while the unit is idle
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_DIMENSION) dim_reg = int'(data[DimW-1:0]);
    else rad_reg = int'(data[RadiusW-1:0]);
  endtask

  // wait until every coordinate is back and the unit has settled
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (coord_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random load beat; out of range rows and columns carry any value
  task automatic random_load();
    int fn;
    int row;
    int col;
    int value;
    fn  = $urandom_range(0, 2);
    row = $urandom_range(0, Dim - 1);
    col = $urandom_range(0, Dim - 1);
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) row = $urandom_range(Dim, 63);
      else col = $urandom_range(Dim, 63);
      if (fn == 2) row = $urandom_range(Dim, 63);
      value = $urandom;
    end else if (fn == 0) begin
      value = $urandom;
    end else if (fn == 1) begin
      value = $urandom_range(0, 32'h10000) - 32'h8000;
    end else begin
      value = (row < 6) ? $urandom_range(32'h10000, 32'h40000)
                        : $urandom_range(32'h40000, 32'h80000);
    end
    send_item(func_e'(fn), row, col, value);
  endtask

  stim_t directed[$];

  initial begin
    stim_t r;
    int    dim;
    n_errors = 0;
    n_items = 0;
    n_starts = 0;
    n_coords = 0;
    n_found = 0;
    zero_pending = 0;
    hold_req = 0;
    quiet = 0;
    dim_reg = int'(DimReset);
    rad_reg = int'(RadiusReset);
    in_if.valid      <= 1'b0;
    in_if.func       <= FUNC_BASIS;
    in_if.row_index  <= '0;
    in_if.col_index  <= '0;
    in_if.load_value <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_DIMENSION;
    cfg_if.data      <= '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every store entry so no run reads an unwritten one
    for (int i = 0; i < Dim; i++) begin
      send_item(FUNC_NORM, i, 0, (i < 6) ? $urandom_range(32'h10000, 32'h40000)
                                         : $urandom_range(32'h40000, 32'h80000));
      for (int j = 0; j < Dim; j++) begin
        send_item(FUNC_BASIS, i, j, $urandom);
        send_item(FUNC_MU, i, j, $urandom_range(0, 32'h10000) - 32'h8000);
      end
    end

    // reset settings: dimension 16 radius 100
    send_item(FUNC_START, 0, 0, 0);
    drain();

    // directed: clamped dimensions, extreme radii, saturation, ignored loads
    write_reg(CFG_DIMENSION, 32'hFFFF_FF82);
    write_reg(CFG_RADIUS, 32'd1);
    directed = '{
      '{FUNC_START, 6'd0,  6'd0,  32'sd0, 1'b1}
    };
    foreach (directed[i]) begin
      zero_pending = directed[i].zero_vec;
      send_item(directed[i].fn, directed[i].row, directed[i].col, directed[i].value);
    end
    drain();
    write_reg(CFG_DIMENSION, 32'd127);
    zero_pending = 1;
    send_item(FUNC_START, 0, 0, 0);
    drain();

    write_reg(CFG_DIMENSION, 32'd1);
    write_reg(CFG_RADIUS, 32'h7FFF_FFFF);
    directed = '{
      '{FUNC_NORM,  6'd0,  6'd0,  32'h7FFF_FFFF, 1'b0},
      '{FUNC_NORM,  6'd1,  6'd63, 32'h7FFF_FFFF, 1'b0},
      '{FUNC_MU,    6'd1,  6'd0,  32'h7FFF_FFFF, 1'b0},
      '{FUNC_BASIS, 6'd0,  6'd0,  32'h7FFF_FFFF, 1'b0},
      '{FUNC_BASIS, 6'd1,  6'd0,  32'h8000_0000, 1'b0},
      '{FUNC_BASIS, 6'd0,  6'd1,  32'hFFFF_FFFF, 1'b0},
      '{FUNC_BASIS, 6'd63, 6'd5,  32'h5555_AAAA, 1'b0},
      '{FUNC_MU,    6'd5,  6'd63, 32'hAAAA_5555, 1'b0},
      '{FUNC_NORM,  6'd40, 6'd0,  32'hFFFF_FFFF, 1'b0},
      '{FUNC_START, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0},
      '{FUNC_NORM,  6'd0,  6'd0,  32'h8000_0000, 1'b0},
      '{FUNC_START, 6'd0,  6'd0,  32'h0,         1'b0},
      '{FUNC_NORM,  6'd0,  6'd0,  32'h0,         1'b0},
      '{FUNC_START, 6'd0,  6'd0,  32'h0,         1'b0},
      '{FUNC_NORM,  6'd0,  6'd0,  32'h0001_0000, 1'b0},
      '{FUNC_NORM,  6'd1,  6'd0,  32'h0001_0000, 1'b0},
      '{FUNC_MU,    6'd1,  6'd0,  32'h0000_8000, 1'b0}
    };
    foreach (directed[i]) begin
      zero_pending = directed[i].zero_vec;
      send_item(directed[i].fn, directed[i].row, directed[i].col, directed[i].value);
    end
    drain();

    // full dimension, with a long result stall while loads keep coming
    write_reg(CFG_DIMENSION, 32'd16);
    write_reg(CFG_RADIUS, 32'd3);
    hold_req = 1;
    send_item(FUNC_START, 0, 0, 0);
    repeat (4) random_load();
    drain();

    // random phases: new settings, a few loads, then a run
    while (n_items < 553 + NumRandom) begin
      if (n_items > 553 + NumRandom - 40) quiet = 1;
      dim = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 5) : $urandom_range(6, 16);
      write_reg(CFG_DIMENSION, {$urandom} & ~32'h7F | 32'(dim));
      write_reg(CFG_RADIUS, (dim > 5) ? 32'($urandom_range(1, 2)) : 32'($urandom_range(1, 20)));
      repeat ($urandom_range(2, 6)) random_load();
      send_item(FUNC_START, 0, 0, 0);
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d input beats, %0d runs (%0d with a vector found), %0d coordinates",
             n_items, n_starts, n_found, n_coords);
    if (n_errors == 0 && coord_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/lsve_pkg.sv
src/lsve_if.sv
src/lsve_mul.sv
src/lsve_store.sv
src/lsve_core.sv
src/lattice_shortest_vector_enum_unit.sv
tb/tb_lattice_shortest_vector_enum_unit.sv
